// ===== sv/system_coprocessor_register_file_defines.svh =====
// Assertion macros for the system coprocessor register file.
`ifndef SYSTEM_COPROCESSOR_REGISTER_FILE_DEFINES_SVH
`define SYSTEM_COPROCESSOR_REGISTER_FILE_DEFINES_SVH

// Property checked at every clock edge outside reset.
`define SCR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SCR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/scr_pkg.sv =====
// Shared constants, types and tables of the system coprocessor register file.
`default_nettype none
package scr_pkg;

  localparam int unsigned RegCount = 28;
  localparam int unsigned IdxW     = $clog2(RegCount);

  typedef logic [IdxW-1:0] reg_idx_t;

  // Stored register slots
  localparam reg_idx_t IxControl = IdxW'(0);
  localparam reg_idx_t IxAux     = IdxW'(1);
  localparam reg_idx_t IxDcLock  = IdxW'(11);
  localparam reg_idx_t IxPrrr    = IdxW'(13);
  localparam reg_idx_t IxNmrr    = IdxW'(14);
  localparam reg_idx_t IxPid     = IdxW'(15);
  localparam reg_idx_t IxCtxId   = IdxW'(16);
  localparam reg_idx_t IxUprw    = IdxW'(17);
  localparam reg_idx_t IxUro     = IdxW'(18);
  localparam reg_idx_t IxPrw     = IdxW'(19);

  localparam logic [31:0] RstControl = 32'h0005_4078;
  localparam logic [31:0] RstAux     = 32'h0000_000F;
  localparam logic [31:0] RstDcLock  = 32'hFFFF_FFF0;
  localparam logic [31:0] RstPrrr    = 32'h0009_8AA4;
  localparam logic [31:0] RstNmrr    = 32'h44E0_48E0;

  localparam logic [31:0] IdMain     = 32'h410F_B024;
  localparam logic [31:0] IdTlbType  = 32'h0000_0800;

  localparam logic OpRead  = 1'b0;
  localparam logic OpWrite = 1'b1;

  // Access decode handed from the decoder to the datapath
  typedef struct packed {
    logic        rd_hit;
    logic        rd_use_reg;
    reg_idx_t    rd_idx;
    logic [31:0] rd_const;
    logic        wr_en;
    reg_idx_t    wr_idx;
  } scr_dec_t;

  function automatic logic [31:0] reset_value(input reg_idx_t idx);
    logic [31:0] v;
    v = '0;
    case (idx)
      IxControl: v = RstControl;
      IxAux:     v = RstAux;
      IxDcLock:  v = RstDcLock;
      IxPrrr:    v = RstPrrr;
      IxNmrr:    v = RstNmrr;
      default:   v = '0;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] id_crm1(input logic [2:0] o2);
    logic [31:0] v;
    v = '0;
    case (o2)
      3'd0:    v = 32'h0000_0111;
      3'd1:    v = 32'h0000_0001;
      3'd2:    v = 32'h0000_0002;
      3'd4:    v = 32'h0110_0103;
      3'd5:    v = 32'h1002_0302;
      3'd6:    v = 32'h0122_2000;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] id_crm2(input logic [2:0] o2);
    logic [31:0] v;
    v = '0;
    case (o2)
      3'd0:    v = 32'h0010_0011;
      3'd1:    v = 32'h1200_2111;
      3'd2:    v = 32'h1122_1011;
      3'd3:    v = 32'h0110_2131;
      3'd4:    v = 32'h0000_0141;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== sv/scr_decode.sv =====
// Selector and privilege decode for one coprocessor access.
`default_nettype none
module scr_decode (
  input  wire logic            operation_i,
  input  wire logic            privileged_i,
  input  wire logic [3:0]      crn_i,
  input  wire logic [2:0]      op_one_i,
  input  wire logic [3:0]      crm_i,
  input  wire logic [2:0]      op_two_i,
  output scr_pkg::scr_dec_t    dec_o
);

  typedef struct packed {
    logic             hit;
    scr_pkg::reg_idx_t idx;
  } sel_t;

  // Stored registers reachable by privileged reads and writes outside crn 13
  function automatic sel_t common_index(input logic [3:0] crn, input logic [2:0] o1,
                                        input logic [3:0] crm, input logic [2:0] o2);
    sel_t s;
    s.hit = 1'b0;
    s.idx = '0;
    if ((crn == 4'd1 || crn == 4'd2) && o1 == 3'd0 && crm == 4'd0 && o2 <= 3'd2) begin
      s.hit = 1'b1;
      s.idx = scr_pkg::IdxW'((crn == 4'd2 ? 3 : 0) + o2);
    end else if (crn == 4'd3 && o1 == 3'd0 && crm == 4'd0 && o2 == 3'd0) begin
      s.hit = 1'b1;
      s.idx = scr_pkg::IdxW'(6);
    end else if ((crn == 4'd5 || crn == 4'd6) && o1 == 3'd0 && crm == 4'd0
                 && o2 <= 3'd1) begin
      s.hit = 1'b1;
      s.idx = scr_pkg::IdxW'(7 + (crn == 4'd6 ? 2 : 0) + o2);
    end else if (crn == 4'd9 && o1 == 3'd0 && crm == 4'd0 && o2 == 3'd0) begin
      s.hit = 1'b1;
      s.idx = scr_pkg::IxDcLock;
    end else if (crn == 4'd10 && o1 == 3'd0 && crm == 4'd0 && o2 == 3'd0) begin
      s.hit = 1'b1;
      s.idx = scr_pkg::IdxW'(12);
    end else if (crn == 4'd10 && o1 == 3'd0 && crm == 4'd2 && o2 <= 3'd1) begin
      s.hit = 1'b1;
      s.idx = scr_pkg::IdxW'(13 + o2);
    end else if (crn == 4'd15 && o1 == 3'd0 && crm == 4'd12 && o2 <= 3'd3) begin
      s.hit = 1'b1;
      s.idx = scr_pkg::IdxW'(20 + o2);
    end else if (crn == 4'd15 && o1 == 3'd5 && o2 == 3'd2 && crm >= 4'd5
                 && crm <= 4'd7) begin
      s.hit = 1'b1;
      s.idx = scr_pkg::IdxW'(24 + (crm - 4'd5));
    end else if (crn == 4'd15 && o1 == 3'd7 && crm == 4'd1 && o2 == 3'd0) begin
      s.hit = 1'b1;
      s.idx = scr_pkg::IdxW'(27);
    end
    return s;
  endfunction

  sel_t common;
  logic thread_sel;

  assign common     = common_index(crn_i, op_one_i, crm_i, op_two_i);
  assign thread_sel = crn_i == 4'd13 && op_one_i == 3'd0 && crm_i == 4'd0;

  always_comb begin
    dec_o = '0;
    if (operation_i == scr_pkg::OpWrite) begin
      if (thread_sel) begin
        if (op_two_i == 3'd2) begin
          dec_o.wr_en  = 1'b1;
          dec_o.wr_idx = scr_pkg::IxUprw;
        end else if (privileged_i) begin
          dec_o.wr_en = op_two_i == 3'd0 || op_two_i == 3'd1 || op_two_i == 3'd3
                        || op_two_i == 3'd4;
          case (op_two_i)
            3'd0:    dec_o.wr_idx = scr_pkg::IxPid;
            3'd1:    dec_o.wr_idx = scr_pkg::IxCtxId;
            3'd3:    dec_o.wr_idx = scr_pkg::IxUro;
            default: dec_o.wr_idx = scr_pkg::IxPrw;
          endcase
        end
      end else if (privileged_i && crn_i != 4'd13) begin
        dec_o.wr_en  = common.hit;
        dec_o.wr_idx = common.idx;
      end
    end else begin
      if (thread_sel && (op_two_i == 3'd2 || op_two_i == 3'd3)) begin
        // user-readable thread registers
        dec_o.rd_hit     = 1'b1;
        dec_o.rd_use_reg = 1'b1;
        dec_o.rd_idx     = op_two_i == 3'd2 ? scr_pkg::IxUprw : scr_pkg::IxUro;
      end else if (!privileged_i) begin
        dec_o.rd_hit = 1'b0;
      end else if (crn_i == 4'd0 && op_one_i == 3'd0) begin
        // identity block; cache type and CPU ID read as zero
        if (crm_i == 4'd0) begin
          dec_o.rd_hit = op_two_i == 3'd0 || op_two_i == 3'd1 || op_two_i == 3'd3
                         || op_two_i == 3'd5;
          dec_o.rd_const = op_two_i == 3'd0 ? scr_pkg::IdMain
                         : op_two_i == 3'd3 ? scr_pkg::IdTlbType : 32'h0;
        end else if (crm_i == 4'd1) begin
          dec_o.rd_hit   = op_two_i != 3'd3;
          dec_o.rd_const = scr_pkg::id_crm1(op_two_i);
        end else if (crm_i == 4'd2) begin
          dec_o.rd_hit   = op_two_i <= 3'd4;
          dec_o.rd_const = scr_pkg::id_crm2(op_two_i);
        end
      end else if (crn_i == 4'd7 && op_one_i == 3'd0 && crm_i == 4'd4 && op_two_i == 3'd0) begin
        dec_o.rd_hit = 1'b1;
      end else if (crn_i == 4'd13) begin
        // process/context ID reads ignore op_one
        dec_o.rd_hit     = crm_i == 4'd0 && (op_two_i == 3'd0 || op_two_i == 3'd1
                                             || op_two_i == 3'd4);
        dec_o.rd_use_reg = 1'b1;
        case (op_two_i)
          3'd0:    dec_o.rd_idx = scr_pkg::IxPid;
          3'd1:    dec_o.rd_idx = scr_pkg::IxCtxId;
          default: dec_o.rd_idx = scr_pkg::IxPrw;
        endcase
      end else begin
        dec_o.rd_hit     = common.hit;
        dec_o.rd_use_reg = 1'b1;
        dec_o.rd_idx     = common.idx;
      end
    end
  end

endmodule
`default_nettype wire

// ===== sv/scr_regfile.sv =====
// Stored system control registers: one write and one read port.
`default_nettype none
module scr_regfile (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              wr_en_i,
  input  wire scr_pkg::reg_idx_t wr_idx_i,
  input  wire logic [31:0]       wr_data_i,
  input  wire scr_pkg::reg_idx_t rd_idx_i,
  output logic [31:0]            rd_data_o
);

  logic [31:0] regs_q [scr_pkg::RegCount];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < scr_pkg::RegCount; i++) begin
        regs_q[i] <= scr_pkg::reset_value(scr_pkg::IdxW'(i));
      end
    end else if (wr_en_i && wr_idx_i < scr_pkg::IdxW'(scr_pkg::RegCount)) begin
      regs_q[wr_idx_i] <= wr_data_i;
    end
  end

  assign rd_data_o = rd_idx_i < scr_pkg::IdxW'(scr_pkg::RegCount) ? regs_q[rd_idx_i] : '0;

endmodule
`default_nettype wire

// ===== sv/system_coprocessor_register_file.sv =====
// Top level of the system coprocessor register file.
//
// Input channel: in_valid_i / in_stall_o carry one coprocessor access per
// transaction (operation, privilege, crn/op1/crm/op2 selector, write value).
// Output channel: out_valid_o / out_stall_i carry one result per access:
// read_value_o and unimplemented_o. A write returns zero with the flag clear.
// An accepted access lands in the input register; once it advances it is
// decoded, the register file is read or written, and the result is
// registered in the output register and offered on the output channel.
// Throughput is one access per cycle while the output is not stalled; a
// write is visible to the very next access. The output register and the
// input register form two slots: with the output stalled, one more access
// is taken and held, then in_stall_o rises until the result is taken.
// Reset empties both slots and loads the stored registers with their
// power-on values; identity registers are constants.
`default_nettype none
module system_coprocessor_register_file (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        operation_i,
  input  wire logic        privileged_i,
  input  wire logic [3:0]  crn_i,
  input  wire logic [2:0]  op_one_i,
  input  wire logic [3:0]  crm_i,
  input  wire logic [2:0]  op_two_i,
  input  wire logic [31:0] write_value_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [31:0]      read_value_o,
  output logic             unimplemented_o
);

  `include "system_coprocessor_register_file_defines.svh"

  logic        s1_valid_q, s1_valid_d;
  logic        op_q, priv_q;
  logic [3:0]  crn_q, crm_q;
  logic [2:0]  op_one_q, op_two_q;
  logic [31:0] wval_q;

  logic        out_valid_q, out_valid_d;
  logic [31:0] read_value_q, read_value_d;
  logic        unimpl_q, unimpl_d;

  logic        in_accept, advance;
  scr_pkg::scr_dec_t dec;
  logic [31:0] rf_rdata;

  assign advance    = s1_valid_q && !(out_valid_q && out_stall_i);
  assign in_stall_o = s1_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign s1_valid_d  = in_accept || (s1_valid_q && !advance);
  assign out_valid_d = advance || (out_valid_q && out_stall_i);

  scr_decode u_decode (
    .operation_i  (op_q),
    .privileged_i (priv_q),
    .crn_i        (crn_q),
    .op_one_i     (op_one_q),
    .crm_i        (crm_q),
    .op_two_i     (op_two_q),
    .dec_o        (dec)
  );

  scr_regfile u_regfile (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (advance && dec.wr_en),
    .wr_idx_i  (dec.wr_idx),
    .wr_data_i (wval_q),
    .rd_idx_i  (dec.rd_idx),
    .rd_data_o (rf_rdata)
  );

  always_comb begin
    read_value_d = '0;
    unimpl_d     = 1'b0;
    if (op_q == scr_pkg::OpRead) begin
      unimpl_d = !dec.rd_hit;
      if (dec.rd_hit) begin
        read_value_d = dec.rd_use_reg ? rf_rdata : dec.rd_const;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q     <= operation_i;
      priv_q   <= privileged_i;
      crn_q    <= crn_i;
      op_one_q <= op_one_i;
      crm_q    <= crm_i;
      op_two_q <= op_two_i;
      wval_q   <= write_value_i;
    end
    if (advance) begin
      read_value_q <= read_value_d;
      unimpl_q     <= unimpl_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign read_value_o    = read_value_q;
  assign unimplemented_o = unimpl_q;

  `SCR_ASSERT_NEXT(a_write_result_clean, advance && op_q == scr_pkg::OpWrite,
                   read_value_o == 32'h0 && !unimplemented_o,
                   "write transaction produced a nonzero result")
  `SCR_ASSERT(a_unimpl_reads_zero, !(out_valid_o && unimplemented_o) || read_value_o == 32'h0,
              "unimplemented read returned data")
  `SCR_ASSERT_NEXT(a_held_item_kept, s1_valid_q && !advance, s1_valid_q && out_valid_o,
                   "held transaction dropped")

endmodule
`default_nettype wire
